### rtl/core/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, codes and widths for the stretch blit engine.
// ----------------------------------------------------------------------------
package sbe_pkg;

   localparam int COORD_W = 16;
   localparam int ADDR_W  = 32;
   localparam int FRAC_W  = 16;
   localparam int STEP_W  = COORD_W + FRAC_W;
   localparam int PITCH_W = 20;
   localparam int BPP_W   = 3;
   localparam int PIX_W   = 32;
   localparam int CSR_IDX_W = 3;

   // Command codes of the request channel
   localparam logic [1:0] CMD_START    = 2'd0;
   localparam logic [1:0] CMD_PIXEL    = 2'd1;
   localparam logic [1:0] CMD_FILL_ADV = 2'd2;

   // Blit modes
   localparam logic [1:0] MODE_FILL  = 2'd0;
   localparam logic [1:0] MODE_COPY  = 2'd1;
   localparam logic [1:0] MODE_KEYED = 2'd2;
   localparam logic [1:0] MODE_ALIAS = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_BASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_BASE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_PITCH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_PITCH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BPP       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH  = 3'd6;

   localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_UNSUP = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_MUL,
      ST_ROW,
      ST_PIX,
      ST_PUT_WR,
      ST_ADV,
      ST_PUT_READ,
      ST_PUT_DONE,
      ST_PUT_UNSUP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic     accept;
      logic     div_start;
      logic     step_load;
      logic     mul_load;
      logic     row_load;
      logic     adv;
      logic     out_load;
      kind_type out_kind;
      logic     out_last;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       unsup;
      logic       zero;
      logic       div_done;
      logic       keep;
      logic       finish;
      logic       row_wrap;
      logic [1:0] mode;
      logic       out_free;
   } dp_sts_type;

   // Mask of the pixel width; sizes other than 1 to 3 bytes keep all bits
   function automatic logic [PIX_W-1:0] pix_mask(input logic [BPP_W-1:0] bpp);
      logic [PIX_W-1:0] m;
      case (bpp)
         3'd1: m = 32'h0000_00ff;
         3'd2: m = 32'h0000_ffff;
         3'd3: m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

### rtl/core/sbe_div.sv
// ----------------------------------------------------------------------------
// sbe_div
// Restoring divider for the 16.16 step: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbe_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sbe_pkg::STEP_W-1:0]     dividend,
   input  logic [sbe_pkg::COORD_W-1:0]    divisor,
   output logic                           done,
   output logic [sbe_pkg::STEP_W-1:0]     quotient
);
   import sbe_pkg::*;

   localparam int CNT_W = $clog2(STEP_W);

   logic [STEP_W-1:0]  quo_ff, quo_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COORD_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [COORD_W:0]   trial;
   logic [COORD_W:0]   diff;

   // One restoring step
   always_comb begin
      trial = {rem_ff, quo_ff[STEP_W-1]};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[COORD_W]) begin
            rem_in = diff[COORD_W-1:0];
            quo_in = {quo_ff[STEP_W-2:0], 1'b1};
         end else begin
            rem_in = trial[COORD_W-1:0];
            quo_in = {quo_ff[STEP_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEP_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/sbe_datapath.sv
// ----------------------------------------------------------------------------
// sbe_datapath
// Registers, walk counters, step dividers, address math and the result beat.
// ----------------------------------------------------------------------------
module sbe_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  sbe_pkg::ctrl_cmd_type            cmd,
   output sbe_pkg::dp_sts_type              sts,
   input  logic [1:0]                       req_cmd,
   input  logic [1:0]                       req_blit_mode,
   input  logic [sbe_pkg::COORD_W-1:0]      req_src_left,
   input  logic [sbe_pkg::COORD_W-1:0]      req_src_top,
   input  logic [sbe_pkg::COORD_W-1:0]      req_src_width,
   input  logic [sbe_pkg::COORD_W-1:0]      req_src_height,
   input  logic [sbe_pkg::COORD_W-1:0]      req_dst_left,
   input  logic [sbe_pkg::COORD_W-1:0]      req_dst_top,
   input  logic [sbe_pkg::COORD_W-1:0]      req_dst_width,
   input  logic [sbe_pkg::COORD_W-1:0]      req_dst_height,
   input  logic [sbe_pkg::PIX_W-1:0]        req_pixel_value,
   input  logic                             csr_write_en,
   input  logic [sbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic [sbe_pkg::ADDR_W-1:0]       rsp_address,
   output logic [sbe_pkg::PIX_W-1:0]        rsp_write_data,
   output logic                             rsp_last
);
   import sbe_pkg::*;

   localparam int PROD_W = COORD_W + 1 + PITCH_W;

   // Configuration registers
   logic [ADDR_W-1:0]  src_base_ff, dst_base_ff;
   logic [PITCH_W-1:0] src_pitch_ff, dst_pitch_ff;
   logic [BPP_W-1:0]   bpp_ff;
   logic [PIX_W-1:0]   key_low_ff, key_high_ff;

   // Blit state
   logic [1:0]         mode_ff;
   logic [COORD_W-1:0] s_left_ff, s_top_ff, d_left_ff, d_top_ff;
   logic [COORD_W-1:0] s_w_ff, s_h_ff, d_w_ff, d_h_ff;
   logic [PIX_W-1:0]   fill_ff, pix_ff;
   logic [COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [STEP_W-1:0]  x_step_ff, y_step_ff;
   logic [STEP_W-1:0]  x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic [ADDR_W-1:0]  src_prod_ff, dst_prod_ff;
   logic [ADDR_W-1:0]  src_row_ff, dst_row_ff;

   // Result beat
   logic               out_valid_ff;
   kind_type           out_kind_ff;
   logic [ADDR_W-1:0]  out_addr_ff;
   logic [PIX_W-1:0]   out_data_ff;
   logic               out_last_ff;

   logic               x_done, y_done;
   logic [STEP_W-1:0]  x_quo, y_quo;
   logic [COORD_W:0]   col_nx, row_nx, srow, drow;
   logic [PROD_W-1:0]  src_prod, dst_prod;
   logic [PIX_W-1:0]   mask, pix_v, wr_data;
   logic [ADDR_W-1:0]  src_addr, dst_addr;
   logic               wrap;

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff  <= '0;
         dst_base_ff  <= '0;
         src_pitch_ff <= '0;
         dst_pitch_ff <= '0;
         bpp_ff       <= BPP_RESET;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SRC_BASE:  src_base_ff  <= csr_wdata;
            CSR_DST_BASE:  dst_base_ff  <= csr_wdata;
            CSR_SRC_PITCH: src_pitch_ff <= csr_wdata[PITCH_W-1:0];
            CSR_DST_PITCH: dst_pitch_ff <= csr_wdata[PITCH_W-1:0];
            CSR_BPP:       bpp_ff       <= csr_wdata[BPP_W-1:0];
            CSR_KEY_LOW:   key_low_ff   <= csr_wdata;
            CSR_KEY_HIGH:  key_high_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Step dividers, both run the same length
   sbe_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({s_w_ff, {FRAC_W{1'b0}}}),
      .divisor  (d_w_ff),
      .done     (x_done),
      .quotient (x_quo)
   );

   sbe_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({s_h_ff, {FRAC_W{1'b0}}}),
      .divisor  (d_h_ff),
      .done     (y_done),
      .quotient (y_quo)
   );

   // Walk arithmetic
   always_comb begin
      col_nx   = {1'b0, col_ff} + 1'b1;
      row_nx   = {1'b0, row_ff} + 1'b1;
      wrap     = col_nx >= {1'b0, d_w_ff};
      srow     = {1'b0, s_top_ff} + {1'b0, y_acc_ff[STEP_W-1:FRAC_W]};
      drow     = {1'b0, d_top_ff} + {1'b0, row_ff};
      src_prod = PROD_W'(srow) * PROD_W'(src_pitch_ff);
      dst_prod = PROD_W'(drow) * PROD_W'(dst_pitch_ff);
      mask     = pix_mask(bpp_ff);
      pix_v    = pix_ff & mask;
      wr_data  = (mode_ff == MODE_FILL) ? (fill_ff & mask) : pix_v;
      src_addr = src_row_ff
               + ADDR_W'(x_acc_ff[STEP_W-1:FRAC_W] * {{(COORD_W-BPP_W){1'b0}}, bpp_ff});
      dst_addr = dst_row_ff + ADDR_W'(col_ff * {{(COORD_W-BPP_W){1'b0}}, bpp_ff});
   end

   // Next walk position
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      x_acc_in = x_acc_ff;
      y_acc_in = y_acc_ff;
      if (cmd.accept && req_cmd == CMD_START) begin
         col_in   = '0;
         row_in   = '0;
         x_acc_in = '0;
         y_acc_in = '0;
      end else if (cmd.adv) begin
         if (wrap) begin
            col_in   = '0;
            x_acc_in = '0;
            row_in   = row_nx[COORD_W-1:0];
            y_acc_in = y_acc_ff + y_step_ff;
         end else begin
            col_in   = col_nx[COORD_W-1:0];
            x_acc_in = x_acc_ff + x_step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_FILL;
         col_ff   <= '0;
         row_ff   <= '0;
         x_acc_ff <= '0;
         y_acc_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         x_acc_ff <= x_acc_in;
         y_acc_ff <= y_acc_in;
         if (cmd.accept && req_cmd == CMD_START) begin
            mode_ff <= (req_blit_mode == MODE_ALIAS) ? MODE_COPY : req_blit_mode;
         end
      end
   end

   // Latch the beat payload and blit geometry
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= req_pixel_value;
         if (req_cmd == CMD_START) begin
            s_left_ff <= req_src_left;
            s_top_ff  <= req_src_top;
            s_w_ff    <= req_src_width;
            s_h_ff    <= req_src_height;
            d_left_ff <= req_dst_left;
            d_top_ff  <= req_dst_top;
            d_w_ff    <= req_dst_width;
            d_h_ff    <= req_dst_height;
            fill_ff   <= req_pixel_value;
         end
      end
      if (cmd.step_load) begin
         x_step_ff <= x_quo;
         y_step_ff <= y_quo;
      end
      if (cmd.mul_load) begin
         src_prod_ff <= src_prod[ADDR_W-1:0];
         dst_prod_ff <= dst_prod[ADDR_W-1:0];
      end
      if (cmd.row_load) begin
         src_row_ff <= src_base_ff + src_prod_ff
                     + ADDR_W'(s_left_ff * {{(COORD_W-BPP_W){1'b0}}, bpp_ff});
         dst_row_ff <= dst_base_ff + dst_prod_ff
                     + ADDR_W'(d_left_ff * {{(COORD_W-BPP_W){1'b0}}, bpp_ff});
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_kind_ff <= cmd.out_kind;
         out_last_ff <= cmd.out_last;
         case (cmd.out_kind)
            KIND_READ: begin
               out_addr_ff <= src_addr;
               out_data_ff <= '0;
            end
            KIND_WRITE: begin
               out_addr_ff <= dst_addr;
               out_data_ff <= wr_data;
            end
            default: begin
               out_addr_ff <= '0;
               out_data_ff <= '0;
            end
         endcase
      end
   end

   // Status to the controller
   always_comb begin
      sts.unsup    = (bpp_ff < 3'd1) || (bpp_ff > 3'd4)
                   || (bpp_ff == 3'd3 && mode_ff != MODE_COPY);
      sts.zero     = (d_w_ff == '0) || (d_h_ff == '0);
      sts.div_done = x_done && y_done;
      sts.keep     = (mode_ff != MODE_KEYED) || (pix_v < key_low_ff) || (pix_v > key_high_ff);
      sts.finish   = wrap && (row_nx >= {1'b0, d_h_ff});
      sts.row_wrap = wrap;
      sts.mode     = mode_ff;
      sts.out_free = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_address    = out_addr_ff;
   assign rsp_write_data = out_data_ff;
   assign rsp_last       = out_last_ff;

endmodule

### rtl/core/sbe_ctrl.sv
// ----------------------------------------------------------------------------
// sbe_ctrl
// Sequencer: takes request beats, runs start, row setup and pixel steps.
// ----------------------------------------------------------------------------
module sbe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   output sbe_pkg::ctrl_cmd_type  cmd,
   input  sbe_pkg::dp_sts_type    sts
);
   import sbe_pkg::*;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      accept;

   assign accept = req_valid && !req_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_START: begin
                     state_in = ST_START;
                     busy_in  = 1'b0;
                  end
                  CMD_PIXEL: if (busy_ff && sts.mode != MODE_FILL) state_in = ST_PIX;
                  CMD_FILL_ADV: if (busy_ff && sts.mode == MODE_FILL) state_in = ST_PIX;
                  default: ;
               endcase
            end
         end
         ST_START: begin
            if (sts.unsup) state_in = ST_PUT_UNSUP;
            else if (sts.zero) state_in = ST_PUT_DONE;
            else state_in = ST_DIV;
         end
         ST_DIV: if (sts.div_done) state_in = ST_MUL;
         ST_MUL: state_in = ST_ROW;
         ST_ROW: begin
            busy_in  = 1'b1;
            state_in = (sts.mode == MODE_FILL) ? ST_IDLE : ST_PUT_READ;
         end
         ST_PIX: state_in = sts.keep ? ST_PUT_WR : ST_ADV;
         ST_PUT_WR: if (sts.out_free) state_in = ST_ADV;
         ST_ADV: begin
            if (sts.finish) begin
               state_in = ST_PUT_DONE;
               busy_in  = 1'b0;
            end else if (sts.row_wrap) begin
               state_in = ST_MUL;
            end else if (sts.mode == MODE_FILL) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_PUT_READ;
            end
         end
         ST_PUT_READ, ST_PUT_DONE, ST_PUT_UNSUP: if (sts.out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      cmd           = '0;
      cmd.out_kind  = KIND_READ;
      cmd.accept    = accept;
      case (state_ff)
         ST_START: cmd.div_start = !sts.unsup && !sts.zero;
         ST_DIV:   cmd.step_load = sts.div_done;
         ST_MUL:   cmd.mul_load  = 1'b1;
         ST_ROW:   cmd.row_load  = 1'b1;
         ST_ADV:   cmd.adv       = 1'b1;
         ST_PUT_WR: begin
            cmd.out_load = sts.out_free;
            cmd.out_kind = KIND_WRITE;
            cmd.out_last = (sts.mode == MODE_FILL) && !sts.finish;
         end
         ST_PUT_READ: begin
            cmd.out_load = sts.out_free;
            cmd.out_kind = KIND_READ;
            cmd.out_last = 1'b1;
         end
         ST_PUT_DONE: begin
            cmd.out_load = sts.out_free;
            cmd.out_kind = KIND_DONE;
            cmd.out_last = 1'b1;
         end
         ST_PUT_UNSUP: begin
            cmd.out_load = sts.out_free;
            cmd.out_kind = KIND_UNSUP;
            cmd.out_last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   // Never overwrite a result that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result beat overwritten while stalled");

   // A start beat always goes through the start check
   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_START) |=> (state_ff == ST_START && !busy_ff))
      else $error("start beat not sequenced");

   // The final pixel ends the blit with done
   a_finish_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV && sts.finish) |=> (state_ff == ST_PUT_DONE && !busy_ff))
      else $error("blit end not reported");

   // Pixel beats are only worked on during a blit
   a_pix_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |-> busy_ff)
      else $error("pixel step outside a blit");

endmodule

### rtl/core/stretch_blit_engine.sv
// ----------------------------------------------------------------------------
// stretch_blit_engine
// Nearest-neighbor stretch blit with fill, copy and source color key.
// ----------------------------------------------------------------------------
// The engine handles one request beat at a time and stalls the request
// channel while it works. A pixel return or fill advance runs decode, the
// write beat (skipped for a keyed-out pixel), the walk step and, outside
// fill mode, the next read beat; a new row first goes through a registered
// pitch multiply and then a base add for its addresses. A start beat waits
// on the two radix-2 step dividers that produce one quotient bit per cycle
// for the 32-bit 16.16 step; an unsupported or empty start skips them. The
// result register lets the next request beat enter while a result waits.
// ----------------------------------------------------------------------------
module stretch_blit_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [1:0]                       req_blit_mode,
   input  logic [sbe_pkg::COORD_W-1:0]      req_src_left,
   input  logic [sbe_pkg::COORD_W-1:0]      req_src_top,
   input  logic [sbe_pkg::COORD_W-1:0]      req_src_width,
   input  logic [sbe_pkg::COORD_W-1:0]      req_src_height,
   input  logic [sbe_pkg::COORD_W-1:0]      req_dst_left,
   input  logic [sbe_pkg::COORD_W-1:0]      req_dst_top,
   input  logic [sbe_pkg::COORD_W-1:0]      req_dst_width,
   input  logic [sbe_pkg::COORD_W-1:0]      req_dst_height,
   input  logic [sbe_pkg::PIX_W-1:0]        req_pixel_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic [sbe_pkg::ADDR_W-1:0]       rsp_address,
   output logic [sbe_pkg::PIX_W-1:0]        rsp_write_data,
   output logic                             rsp_last,
   input  logic                             csr_write_en,
   input  logic [sbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                      csr_wdata
);
   import sbe_pkg::*;

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   // Sequencer
   sbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath
   sbe_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_blit_mode   (req_blit_mode),
      .req_src_left    (req_src_left),
      .req_src_top     (req_src_top),
      .req_src_width   (req_src_width),
      .req_src_height  (req_src_height),
      .req_dst_left    (req_dst_left),
      .req_dst_top     (req_dst_top),
      .req_dst_width   (req_dst_width),
      .req_dst_height  (req_dst_height),
      .req_pixel_value (req_pixel_value),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_address     (rsp_address),
      .rsp_write_data  (rsp_write_data),
      .rsp_last        (rsp_last)
   );

endmodule
